>>> rtl/pfla_pkg.sv
// Shared types and codes for the partitioned free-list allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package pfla_pkg;

   localparam int MODE_W     = 2;
   localparam int PART_W     = 2;
   localparam int BLK_W      = 8;
   localparam int STATUS_W   = 3;
   localparam int TOT_W      = 9;
   localparam int QUOTA_W    = 9;
   localparam int PARTS_W    = 3;
   localparam int QUOTA_REGS = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_PARTS_USED  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUOTA_ZERO  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_QUOTA_ONE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_QUOTA_TWO   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_QUOTA_THREE = 3'd4;

   typedef enum logic [MODE_W-1:0] {
      MODE_ALLOC = 2'd0,
      MODE_FREE  = 2'd1,
      MODE_INIT  = 2'd2,
      MODE_NOP   = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK          = 3'd0,
      STAT_QUOTA_EMPTY = 3'd1,
      STAT_BAD_PART    = 3'd2,
      STAT_BAD_INDEX   = 3'd3,
      STAT_LIST_EMPTY  = 3'd4,
      STAT_QUOTA_OVER  = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_WALK = 3'b100
   } state_type;

   typedef struct packed {
      logic capture;
      logic execute;
      logic walk;
   } ctrl_cmd_type;

   typedef struct packed {
      logic init_ok;
      logic walk_last;
   } dpath_stat_type;

endpackage

>>> rtl/partitioned_free_list_allocator_top.sv
// Allocate, free and no-operation requests first read the head block's link from
// the synchronous link memory and then update the list and the partition credits.
// An initialize request whose quotas fit within MAX_BLOCKS then also rewrites every
// link of the memory, one entry per cycle. After reset the block runs the same link
// setup pass before it takes its first request; configuration writes are taken at
// any time. A result waits in an output register, so a stalled response delays only
// the next request's update.
// Top level of the partitioned free-list allocator.
// Depends on pfla_pkg, pfla_ctrl and pfla_dpath.
module partitioned_free_list_allocator_top
   import pfla_pkg::*;
#(
   parameter int MAX_BLOCKS = 256,
   parameter int MAX_PARTS  = 4
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [MODE_W-1:0]     req_mode,
   input  logic [PART_W-1:0]     req_partition,
   input  logic [BLK_W-1:0]      req_block_index,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [BLK_W-1:0]      rsp_granted_index,
   output logic [TOT_W-1:0]      rsp_total_blocks
);

   ctrl_cmd_type   cmd;
   dpath_stat_type stat;

   pfla_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   pfla_dpath #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .MAX_PARTS  (MAX_PARTS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_mode          (req_mode),
      .req_partition     (req_partition),
      .req_block_index   (req_block_index),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_status        (rsp_status),
      .rsp_granted_index (rsp_granted_index),
      .rsp_total_blocks  (rsp_total_blocks)
   );

   // A result is never written over one that is still waiting.
   a_exec_output_free: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |-> !(rsp_valid && rsp_stall))
      else $error("result register overwritten while stalled");

   // A response appears only after a request was executed.
   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.execute))
      else $error("response raised without an executed request");

   // No request is taken while the link memory is being rewritten.
   a_no_capture_in_walk: assert property (@(posedge clock) disable iff (reset)
      cmd.walk |-> (req_stall && !cmd.capture))
      else $error("request taken during link setup");

endmodule

>>> rtl/pfla_ctrl.sv
// Request sequencer of the partitioned free-list allocator.
// Depends on pfla_pkg; drives the datapath through ctrl_cmd_type.
module pfla_ctrl
   import pfla_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   input  dpath_stat_type stat,
   output ctrl_cmd_type   cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      cmd.walk    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               cmd.execute = 1'b1;
               state_in    = stat.init_ok ? S_WALK : S_IDLE;
            end
         end
         S_WALK: begin
            cmd.walk = 1'b1;
            if (stat.walk_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.execute || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_WALK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/pfla_dpath.sv
// Datapath of the partitioned free-list allocator: registers, credits, link memory.
// Depends on pfla_pkg; sequenced by pfla_ctrl through ctrl_cmd_type.
module pfla_dpath
   import pfla_pkg::*;
#(
   parameter int MAX_BLOCKS = 256,
   parameter int MAX_PARTS  = 4
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data,
   input  logic [MODE_W-1:0]       req_mode,
   input  logic [PART_W-1:0]       req_partition,
   input  logic [BLK_W-1:0]        req_block_index,
   input  ctrl_cmd_type            cmd,
   output dpath_stat_type          stat,
   output logic [STATUS_W-1:0]     rsp_status,
   output logic [BLK_W-1:0]        rsp_granted_index,
   output logic [TOT_W-1:0]        rsp_total_blocks
);

   localparam int LW    = $clog2(MAX_BLOCKS + 1);
   localparam int AW    = $clog2(MAX_BLOCKS);
   localparam int CW    = (LW > BLK_W) ? LW : BLK_W;
   localparam int SUM_W = ((LW > QUOTA_W + 2) ? LW : QUOTA_W + 2) + 1;
   localparam int NCW0  = $clog2(MAX_PARTS + 1);
   localparam int NCW   = (NCW0 > PARTS_W) ? NCW0 : PARTS_W;
   localparam logic [LW-1:0] LIST_END = LW'(MAX_BLOCKS);

   logic [PARTS_W-1:0] parts_used_ff, parts_used_in;
   logic [QUOTA_W-1:0] quota_ff [QUOTA_REGS];
   logic [QUOTA_W-1:0] quota_in [QUOTA_REGS];

   mode_type          mode_ff;
   logic [PART_W-1:0] part_ff;
   logic [BLK_W-1:0]  blk_ff;

   logic [LW-1:0] head_ff, head_in;
   logic [LW-1:0] total_ff, total_in;
   logic [LW-1:0] credit_ff [MAX_PARTS];
   logic [LW-1:0] credit_in [MAX_PARTS];
   logic [AW-1:0] walk_ff, walk_in;

   logic [LW-1:0] link_mem [MAX_BLOCKS];
   logic [LW-1:0] rdata_ff;

   status_type         status_ff;
   logic [BLK_W-1:0]   granted_ff;
   logic [TOT_W-1:0]   total_out_ff;

   logic [NCW-1:0]   active_n;
   logic             part_bad;
   logic [SUM_W-1:0] quota_sum;
   logic             sum_bad;
   logic [LW-1:0]    cred_sel;
   logic             list_empty;
   logic [LW-1:0]    walk_link;
   status_type       status_in;
   logic [BLK_W-1:0] granted_in;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [LW-1:0]    wr_data;

   // Configuration registers.
   always_comb begin
      parts_used_in = parts_used_ff;
      for (int j = 0; j < QUOTA_REGS; j++) begin
         quota_in[j] = quota_ff[j];
      end
      if (csr_write) begin
         unique case (csr_index)
            CSR_PARTS_USED:  parts_used_in = csr_data[PARTS_W-1:0];
            CSR_QUOTA_ZERO:  quota_in[0]   = csr_data[QUOTA_W-1:0];
            CSR_QUOTA_ONE:   quota_in[1]   = csr_data[QUOTA_W-1:0];
            CSR_QUOTA_TWO:   quota_in[2]   = csr_data[QUOTA_W-1:0];
            CSR_QUOTA_THREE: quota_in[3]   = csr_data[QUOTA_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Checks and values used by the request kinds and the link setup pass.
   always_comb begin
      active_n = (NCW'(parts_used_ff) < NCW'(MAX_PARTS)) ? NCW'(parts_used_ff)
                                                          : NCW'(MAX_PARTS);
      part_bad = NCW'(part_ff) >= active_n;
      quota_sum = '0;
      for (int j = 0; j < QUOTA_REGS; j++) begin
         if (NCW'(j) < active_n) begin
            quota_sum = quota_sum + SUM_W'(quota_ff[j]);
         end
      end
      sum_bad = quota_sum > SUM_W'(MAX_BLOCKS);
      cred_sel = '0;
      for (int i = 0; i < MAX_PARTS; i++) begin
         if (NCW'(part_ff) == NCW'(i)) begin
            cred_sel = credit_ff[i];
         end
      end
      list_empty = head_ff >= LIST_END;
      walk_link  = LW'(walk_ff) + LW'(1);
   end

   assign stat.init_ok   = (mode_ff == MODE_INIT) && !sum_bad;
   assign stat.walk_last = (walk_ff == AW'(MAX_BLOCKS - 1));

   always_comb begin
      status_in  = STAT_OK;
      granted_in = '0;
      head_in    = head_ff;
      total_in   = total_ff;
      for (int i = 0; i < MAX_PARTS; i++) begin
         credit_in[i] = credit_ff[i];
      end
      wr_en   = 1'b0;
      wr_addr = walk_ff;
      wr_data = (walk_link < total_ff) ? walk_link : LIST_END;
      walk_in = walk_ff;
      if (cmd.execute) begin
         unique case (mode_ff)
            MODE_INIT: begin
               if (sum_bad) begin
                  status_in = STAT_QUOTA_OVER;
               end else begin
                  for (int i = 0; i < MAX_PARTS; i++) begin
                     credit_in[i] = (i < QUOTA_REGS && NCW'(i) < active_n)
                                    ? LW'(quota_ff[i % QUOTA_REGS]) : '0;
                  end
                  total_in = LW'(quota_sum);
                  head_in  = (quota_sum == '0) ? LIST_END : '0;
               end
            end
            MODE_ALLOC: begin
               priority if (part_bad) begin
                  status_in = STAT_BAD_PART;
               end else if (cred_sel == '0) begin
                  status_in = STAT_QUOTA_EMPTY;
               end else if (list_empty) begin
                  status_in = STAT_LIST_EMPTY;
               end else begin
                  for (int i = 0; i < MAX_PARTS; i++) begin
                     if (NCW'(part_ff) == NCW'(i)) begin
                        credit_in[i] = credit_ff[i] - LW'(1);
                     end
                  end
                  granted_in = BLK_W'(head_ff);
                  head_in    = rdata_ff;
               end
            end
            MODE_FREE: begin
               priority if (part_bad) begin
                  status_in = STAT_BAD_PART;
               end else if (CW'(blk_ff) >= CW'(total_ff)) begin
                  status_in = STAT_BAD_INDEX;
               end else begin
                  for (int i = 0; i < MAX_PARTS; i++) begin
                     if (NCW'(part_ff) == NCW'(i) && credit_ff[i] < LIST_END) begin
                        credit_in[i] = credit_ff[i] + LW'(1);
                     end
                  end
                  wr_en   = 1'b1;
                  wr_addr = AW'(blk_ff);
                  wr_data = head_ff;
                  head_in = LW'(blk_ff);
               end
            end
            MODE_NOP: begin
            end
         endcase
      end
      if (cmd.walk) begin
         wr_en   = 1'b1;
         walk_in = stat.walk_last ? '0 : walk_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parts_used_ff <= PARTS_W'(1);
         quota_ff[0]   <= QUOTA_W'(256);
         for (int j = 1; j < QUOTA_REGS; j++) begin
            quota_ff[j] <= '0;
         end
         head_ff  <= '0;
         total_ff <= LIST_END;
         for (int i = 0; i < MAX_PARTS; i++) begin
            credit_ff[i] <= (i == 0) ? LIST_END : '0;
         end
         walk_ff <= '0;
      end else begin
         parts_used_ff <= parts_used_in;
         for (int j = 0; j < QUOTA_REGS; j++) begin
            quota_ff[j] <= quota_in[j];
         end
         head_ff  <= head_in;
         total_ff <= total_in;
         for (int i = 0; i < MAX_PARTS; i++) begin
            credit_ff[i] <= credit_in[i];
         end
         walk_ff <= walk_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff  <= mode_type'(req_mode);
         part_ff  <= req_partition;
         blk_ff   <= req_block_index;
         rdata_ff <= link_mem[AW'(head_ff)];
      end
      if (wr_en) begin
         link_mem[wr_addr] <= wr_data;
      end
      if (cmd.execute) begin
         status_ff    <= status_in;
         granted_ff   <= granted_in;
         total_out_ff <= TOT_W'(total_in);
      end
   end

   assign rsp_status        = status_ff;
   assign rsp_granted_index = granted_ff;
   assign rsp_total_blocks  = total_out_ff;

endmodule
